// ----- hdl/tcl_pkg.sv -----
// Shared package for the tile cache: default sizes, command codes and the
// command/status bundles between controller and datapath. No dependencies.
`default_nettype none
package tcl_pkg;

  localparam int ENTRIES_DEF     = 64;
  localparam int KEY_BITS_DEF    = 64;
  localparam int HANDLE_BITS_DEF = 32;

  localparam logic [6:0] CAP_MIN = 7'd4;
  localparam logic [6:0] CAP_RST = 7'd64;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_TRIM   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic load;
    logic cap_wr;
    logic scan_start;
    logic upd_start;
    logic upd_evict;
    logic upd_hnd;
    logic insert;
    logic clear;
    logic emit;
    logic em_hit;
    logic em_hnd;
    logic em_evict;
    logic em_last;
  } ctl_t;

  typedef struct packed {
    logic done;
    logic found;
    logic need_evict;
    logic over_lim;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/tcl_dpath.sv -----
// Tile cache datapath: entry memory, valid bits, count, entry sweep and
// result registers. Depends on tcl_pkg.
`default_nettype none
module tcl_dpath #(
  parameter int ENTRIES     = tcl_pkg::ENTRIES_DEF,
  parameter int KEY_BITS    = tcl_pkg::KEY_BITS_DEF,
  parameter int HANDLE_BITS = tcl_pkg::HANDLE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tcl_pkg::ctl_t ctl,
  output tcl_pkg::sts_t      sts,
  input  wire logic [63:0]   in_key,
  input  wire logic [31:0]   in_handle_in,
  input  wire logic [6:0]    cfg_capacity,
  output logic               out_hit,
  output logic [31:0]        out_handle_out,
  output logic               out_evicted,
  output logic [63:0]        out_evicted_key,
  output logic [6:0]         out_occupancy,
  output logic               out_last
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > 7) ? CW : 7;

  logic [KEY_BITS-1:0]    key_r;
  logic [HANDLE_BITS-1:0] hnd_r;
  logic [6:0]             cap_r;
  logic [CW-1:0]          count_r;
  logic [ENTRIES-1:0]     valid_r;

  logic [KEY_BITS-1:0]    mem_key  [ENTRIES];
  logic [HANDLE_BITS-1:0] mem_hnd  [ENTRIES];
  logic [IW-1:0]          mem_rank [ENTRIES];
  logic [KEY_BITS-1:0]    rd_key_r;
  logic [HANDLE_BITS-1:0] rd_hnd_r;
  logic [IW-1:0]          rd_rank_r;

  logic          run_r, upd_r, evict_r, hwr_r, pend_r;
  logic [IW:0]   addr_r;
  logic [IW-1:0] idx_r;

  logic                   fnd_r, freef_r;
  logic [IW-1:0]          slot_r, rank_r, free_r, vic_r;
  logic [HANDLE_BITS-1:0] hout_r;
  logic [KEY_BITS-1:0]    vkey_r;

  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [KEY_BITS-1:0]    wr_key;
  logic [HANDLE_BITS-1:0] wr_hnd;
  logic [IW-1:0]          wr_rank;

  logic [LW-1:0] cap_ext, lim, cnt_ext;
  logic          v, done;
  logic [63:0]   h_in64, h_out64, k_out64;

  assign cap_ext = LW'(cap_r);
  assign lim     = (cap_ext < LW'(ENTRIES)) ? cap_ext : LW'(ENTRIES);
  assign cnt_ext = LW'(count_r);
  assign v       = valid_r[idx_r];
  assign done    = pend_r && (idx_r == IW'(ENTRIES - 1));
  assign h_in64  = 64'(in_handle_in);
  assign h_out64 = 64'(hout_r);
  assign k_out64 = 64'(vkey_r);

  assign sts.done       = done;
  assign sts.found      = fnd_r;
  assign sts.need_evict = (count_r != '0) && (cnt_ext >= lim);
  assign sts.over_lim   = cnt_ext > lim;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_key  = rd_key_r;
    wr_hnd  = rd_hnd_r;
    wr_rank = rd_rank_r;
    if (pend_r && upd_r && v) begin
      if (evict_r) begin
        if (rd_rank_r != '0) begin
          wr_en   = 1'b1;
          wr_rank = rd_rank_r - 1'b1;
        end
      end else if (idx_r == slot_r) begin
        wr_en   = 1'b1;
        wr_rank = IW'(count_r - 1'b1);
        if (hwr_r) begin
          wr_hnd = hnd_r;
        end
      end else if (rd_rank_r > rank_r) begin
        wr_en   = 1'b1;
        wr_rank = rd_rank_r - 1'b1;
      end
    end else if (ctl.insert) begin
      wr_en   = 1'b1;
      wr_addr = free_r;
      wr_key  = key_r;
      wr_hnd  = hnd_r;
      wr_rank = IW'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr]  <= wr_key;
      mem_hnd[wr_addr]  <= wr_hnd;
      mem_rank[wr_addr] <= wr_rank;
    end
    rd_key_r  <= mem_key[addr_r[IW-1:0]];
    rd_hnd_r  <= mem_hnd[addr_r[IW-1:0]];
    rd_rank_r <= mem_rank[addr_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      pend_r  <= 1'b0;
      fnd_r   <= 1'b0;
      freef_r <= 1'b0;
      count_r <= '0;
      valid_r <= '0;
      cap_r   <= tcl_pkg::CAP_RST;
    end else begin
      pend_r <= run_r;
      if (ctl.scan_start || ctl.upd_start) begin
        run_r <= 1'b1;
      end else if (run_r && (addr_r == (IW+1)'(ENTRIES - 1))) begin
        run_r <= 1'b0;
      end
      if (ctl.scan_start) begin
        fnd_r   <= 1'b0;
        freef_r <= 1'b0;
      end else if (pend_r && !upd_r) begin
        if (v && (rd_key_r == key_r)) begin
          fnd_r <= 1'b1;
        end
        if (!v) begin
          freef_r <= 1'b1;
        end
      end
      if (ctl.upd_start && ctl.upd_evict) begin
        valid_r[vic_r] <= 1'b0;
      end
      if (done && upd_r && evict_r) begin
        count_r <= count_r - 1'b1;
      end
      if (ctl.insert) begin
        valid_r[free_r] <= 1'b1;
        count_r         <= count_r + 1'b1;
      end
      if (ctl.clear) begin
        valid_r <= '0;
        count_r <= '0;
      end
      if (ctl.cap_wr) begin
        cap_r <= (cfg_capacity < tcl_pkg::CAP_MIN) ? tcl_pkg::CAP_MIN : cfg_capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= addr_r[IW-1:0];
    if (ctl.scan_start || ctl.upd_start) begin
      addr_r  <= '0;
      upd_r   <= ctl.upd_start;
      evict_r <= ctl.upd_evict;
      hwr_r   <= ctl.upd_hnd;
    end else if (run_r) begin
      addr_r <= addr_r + 1'b1;
    end
    if (ctl.load) begin
      key_r <= in_key[KEY_BITS-1:0];
      hnd_r <= h_in64[HANDLE_BITS-1:0];
    end
    if (pend_r && !upd_r) begin
      if (v && (rd_key_r == key_r) && !fnd_r) begin
        slot_r <= idx_r;
        rank_r <= rd_rank_r;
        hout_r <= rd_hnd_r;
      end
      if (!v && !freef_r) begin
        free_r <= idx_r;
      end
      if (v && (rd_rank_r == '0)) begin
        vic_r  <= idx_r;
        vkey_r <= rd_key_r;
      end
    end
    if (ctl.emit) begin
      out_hit         <= ctl.em_hit;
      out_handle_out  <= ctl.em_hnd ? h_out64[31:0] : 32'd0;
      out_evicted     <= ctl.em_evict;
      out_evicted_key <= ctl.em_evict ? k_out64 : 64'd0;
      out_occupancy   <= 7'(count_r);
      out_last        <= ctl.em_last;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tcl_ctrl.sv -----
// Tile cache controller: command sequencing, handshakes and result ordering.
// Depends on tcl_pkg.
`default_nettype none
module tcl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    in_cmd,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tcl_pkg::ctl_t      ctl,
  input  wire tcl_pkg::sts_t sts
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_DEC  = 7'b0000100,
    S_UPD  = 7'b0001000,
    S_EVEM = 7'b0010000,
    S_INS  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t         state_r, state_nxt;
  tcl_pkg::cmd_t  op_r, op_nxt;
  logic           silent_r, silent_nxt, ev_r, ev_nxt;
  logic           fhit_r, fhit_nxt, fhnd_r, fhnd_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign out_valid = out_valid_r;

  always_comb begin
    ctl        = '0;
    state_nxt  = state_r;
    op_nxt     = op_r;
    silent_nxt = silent_r;
    ev_nxt     = ev_r;
    fhit_nxt   = fhit_r;
    fhnd_nxt   = fhnd_r;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          ctl.cap_wr     = 1'b1;
          ctl.scan_start = 1'b1;
          silent_nxt     = 1'b1;
          op_nxt         = tcl_pkg::CMD_TRIM;
          state_nxt      = S_SCAN;
        end else if (in_valid) begin
          ctl.load   = 1'b1;
          silent_nxt = 1'b0;
          op_nxt     = tcl_pkg::cmd_t'(in_cmd);
          fhit_nxt   = 1'b0;
          fhnd_nxt   = 1'b0;
          if (in_cmd == tcl_pkg::CMD_CLEAR) begin
            ctl.clear = 1'b1;
            state_nxt = S_FIN;
          end else begin
            ctl.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.done) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        ev_nxt = 1'b0;
        unique case (op_r)
          tcl_pkg::CMD_LOOKUP: begin
            if (sts.found) begin
              ctl.upd_start = 1'b1;
              fhit_nxt      = 1'b1;
              fhnd_nxt      = 1'b1;
              state_nxt     = S_UPD;
            end else begin
              state_nxt = S_FIN;
            end
          end
          tcl_pkg::CMD_INSERT: begin
            if (sts.found) begin
              ctl.upd_start = 1'b1;
              ctl.upd_hnd   = 1'b1;
              fhit_nxt      = 1'b1;
              state_nxt     = S_UPD;
            end else if (sts.need_evict) begin
              ctl.upd_start = 1'b1;
              ctl.upd_evict = 1'b1;
              ev_nxt        = 1'b1;
              state_nxt     = S_UPD;
            end else begin
              state_nxt = S_INS;
            end
          end
          tcl_pkg::CMD_TRIM: begin
            if (sts.over_lim) begin
              ctl.upd_start = 1'b1;
              ctl.upd_evict = 1'b1;
              ev_nxt        = 1'b1;
              state_nxt     = S_UPD;
            end else begin
              state_nxt = silent_r ? S_IDLE : S_FIN;
            end
          end
          tcl_pkg::CMD_CLEAR: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_UPD: begin
        if (sts.done) begin
          if (!ev_r) begin
            state_nxt = S_FIN;
          end else if (silent_r) begin
            ctl.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            state_nxt = S_EVEM;
          end
        end
      end
      S_EVEM: begin
        if (out_free) begin
          ctl.emit       = 1'b1;
          ctl.em_evict   = 1'b1;
          ctl.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_INS: begin
        ctl.insert = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          ctl.emit    = 1'b1;
          ctl.em_hit  = fhit_r;
          ctl.em_hnd  = fhnd_r;
          ctl.em_last = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = ctl.emit ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= tcl_pkg::CMD_LOOKUP;
      silent_r    <= 1'b0;
      ev_r        <= 1'b0;
      fhit_r      <= 1'b0;
      fhnd_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      silent_r    <= silent_nxt;
      ev_r        <= ev_nxt;
      fhit_r      <= fhit_nxt;
      fhnd_r      <= fhnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tile_cache_lru.sv -----
// Top level of the tile cache: controller plus datapath.
// Depends on tcl_pkg, tcl_ctrl and tcl_dpath.
//
// Fully associative LRU map from tile key to handle. Each command but clear
// sweeps the entry memory one entry per cycle. A lookup or insert hit runs
// a search sweep, then a recency sweep; a lookup miss runs the search sweep
// alone, an insert into free room the search sweep and then the write, and
// each eviction adds two sweeps (the eviction update and a new search).
// Clear does not sweep. A capacity write drops cfg_ready and raises in_stall
// while excess entries are dropped silently, two sweeps per dropped entry.
// Each eviction comes out as its own item ahead of the final status item,
// which carries last.
`default_nettype none
module tile_cache_lru #(
  parameter int ENTRIES     = tcl_pkg::ENTRIES_DEF,
  parameter int KEY_BITS    = tcl_pkg::KEY_BITS_DEF,
  parameter int HANDLE_BITS = tcl_pkg::HANDLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [63:0] in_key,
  input  wire logic [31:0] in_handle_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_hit,
  output logic [31:0]      out_handle_out,
  output logic             out_evicted,
  output logic [63:0]      out_evicted_key,
  output logic [6:0]       out_occupancy,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_capacity
);

  tcl_pkg::ctl_t ctl;
  tcl_pkg::sts_t sts;

  tcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  tcl_dpath #(
    .ENTRIES     (ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_key          (in_key),
    .in_handle_in    (in_handle_in),
    .cfg_capacity    (cfg_capacity),
    .out_hit         (out_hit),
    .out_handle_out  (out_handle_out),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .out_occupancy   (out_occupancy),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

// ----- hdl/tcl_chk.sv -----
// Port-level checker for the tile cache, bound to tile_cache_lru.
// No package dependencies.
`default_nettype none
module tcl_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_hit,
  input wire logic [31:0] out_handle_out,
  input wire logic        out_evicted,
  input wire logic [63:0] out_evicted_key,
  input wire logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_evicted_key) && $stable(out_last))
    else $error("result item changed while stalled");

  a_evict_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_last && !out_hit && (out_handle_out == 32'd0))
    else $error("eviction item carries status");

  a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_evicted_key == 64'd0)
    else $error("evicted key set without eviction");

  a_handle_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_handle_out != 32'd0) |-> out_hit && out_last)
    else $error("handle returned without hit");

endmodule

bind tile_cache_lru tcl_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_hit         (out_hit),
  .out_handle_out  (out_handle_out),
  .out_evicted     (out_evicted),
  .out_evicted_key (out_evicted_key),
  .out_last        (out_last)
);
`default_nettype wire
